// ----- design/audio_decimating_format_converter_core_defines.svh -----
// Assertion macros used by the converter core RTL.
`ifndef AUDIO_DECIMATING_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define AUDIO_DECIMATING_FORMAT_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ADFC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ADFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ADFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ADFC_ASSERT_ALWAYS(label, expr, msg)
`define ADFC_ASSERT_SAME(label, ante, cons, msg)
`define ADFC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- design/adfc_pkg.sv -----
// Shared constants and types of the audio decimating format converter.
package adfc_pkg;

  localparam int unsigned SOURCE_RATE      = 16000;
  localparam int unsigned MAX_BLOCK_FRAMES = 4096;
  localparam int unsigned BITS_THRESHOLD   = 12;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned BITS_W     = 8;
  localparam int unsigned CRATE_W    = 14;
  localparam int unsigned POS_W      = 26;
  localparam int unsigned PROD_W     = LEN_W + CRATE_W;
  localparam int unsigned SEL_W      = POS_W + 1 + CRATE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(16000);
  localparam logic [BITS_W-1:0] BITS_RESET   = BITS_W'(16);
  localparam logic              STEREO_RESET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_RATE = 2'd0,
    CFG_TARGET_BITS = 2'd1,
    CFG_KEEP_STEREO = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic eight;
    logic stereo;
  } fmt_ctrl_t;

endpackage

// ----- design/adfc_in_if.sv -----
// Input frame channel: valid/ready handshake with one stereo frame per item.
interface adfc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [adfc_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [adfc_pkg::SAMPLE_W-1:0] right_sample;
  logic                                block_start;
  logic [adfc_pkg::LEN_W-1:0]           block_frames;

  modport source (output valid, left_sample, right_sample, block_start, block_frames,
                  input ready);
  modport sink (input valid, left_sample, right_sample, block_start, block_frames,
                output ready);
endinterface

// ----- design/adfc_out_if.sv -----
// Output frame channel: valid/ready handshake with one converted frame per item.
interface adfc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [adfc_pkg::SAMPLE_W-1:0] first_value;
  logic signed [adfc_pkg::SAMPLE_W-1:0] second_value;
  logic                                is_eight_bit;
  logic                                is_stereo;
  logic                                last_of_block;

  modport source (output valid, first_value, second_value, is_eight_bit, is_stereo,
                  last_of_block, input ready);
  modport sink (input valid, first_value, second_value, is_eight_bit, is_stereo,
                last_of_block, output ready);
endinterface

// ----- design/audio_decimating_format_converter_core.sv -----
// Converts 16 kHz stereo frames to a lower rate by dropping frames, with 8/16-bit and mono mix.
// One input frame is accepted every clock cycle unless the input stalls. A kept frame passes
// through the input register and then the result register, which it enters once the input
// register moves on. Frames that are dropped produce no output item. The input stalls only
// while the result register holds an item the sink has not taken and the input register
// is full. Frame selection compares n*16000 against (i+1)*rate with one 27x14 multiplier
// per frame. The block's output count is kept as the product len*rate, formed by a 13x14
// multiplier at block start, so no divider is needed.
`include "audio_decimating_format_converter_core_defines.svh"

module audio_decimating_format_converter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_en,
  input  logic [adfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  adfc_in_if.sink                            in_ch,
  adfc_out_if.source                         out_ch
);

  localparam int unsigned PW = adfc_pkg::PROD_W;
  localparam logic [PW-1:0] STEP1 = PW'(adfc_pkg::SOURCE_RATE);
  localparam logic [PW-1:0] STEP2 = PW'(2 * adfc_pkg::SOURCE_RATE);

  logic [adfc_pkg::RATE_W-1:0] target_rate;
  logic [adfc_pkg::BITS_W-1:0] target_bits;
  logic                        keep_stereo;

  logic                                 s1_valid;
  logic signed [adfc_pkg::SAMPLE_W-1:0] s1_left;
  logic signed [adfc_pkg::SAMPLE_W-1:0] s1_right;
  logic                                 s1_start;
  logic [adfc_pkg::LEN_W-1:0]           s1_len;
  logic                                 s1_move;

  logic [adfc_pkg::POS_W-1:0] in_pos;
  logic [PW-1:0]              prod;
  logic [PW-1:0]              acc;

  logic [adfc_pkg::CRATE_W-1:0] crate;
  logic [adfc_pkg::LEN_W-1:0]   len_clamped;
  logic [PW-1:0]                blk_prod;
  logic [PW-1:0]                prod_cur;
  logic [PW-1:0]                acc_cur;
  logic [PW-1:0]                acc1;
  logic [PW-1:0]                acc2;
  logic [adfc_pkg::POS_W-1:0]   pos_cur;
  logic [adfc_pkg::SEL_W-1:0]   sel_prod;
  logic                         emit;
  logic                         last;

  adfc_pkg::fmt_ctrl_t                  ctrl;
  logic signed [adfc_pkg::SAMPLE_W-1:0] fmt_first;
  logic signed [adfc_pkg::SAMPLE_W-1:0] fmt_second;

  logic                                 out_valid;
  logic signed [adfc_pkg::SAMPLE_W-1:0] out_first;
  logic signed [adfc_pkg::SAMPLE_W-1:0] out_second;
  logic                                 out_eight;
  logic                                 out_stereo;
  logic                                 out_last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate <= adfc_pkg::RATE_RESET;
      target_bits <= adfc_pkg::BITS_RESET;
      keep_stereo <= adfc_pkg::STEREO_RESET;
    end else if (cfg_en) begin
      case (adfc_pkg::cfg_reg_t'(cfg_index))
        adfc_pkg::CFG_TARGET_RATE: target_rate <= cfg_data[adfc_pkg::RATE_W-1:0];
        adfc_pkg::CFG_TARGET_BITS: target_bits <= cfg_data[adfc_pkg::BITS_W-1:0];
        adfc_pkg::CFG_KEEP_STEREO: keep_stereo <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_move     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_left  <= in_ch.left_sample;
      s1_right <= in_ch.right_sample;
      s1_start <= in_ch.block_start;
      s1_len   <= in_ch.block_frames;
    end
  end

  // Frame selection
  always_comb begin
    if (32'(target_rate) > adfc_pkg::SOURCE_RATE) begin
      crate = adfc_pkg::CRATE_W'(adfc_pkg::SOURCE_RATE);
    end else if (target_rate == '0) begin
      crate = adfc_pkg::CRATE_W'(1);
    end else begin
      crate = target_rate[adfc_pkg::CRATE_W-1:0];
    end
  end

  assign len_clamped = (32'(s1_len) > adfc_pkg::MAX_BLOCK_FRAMES)
                     ? adfc_pkg::LEN_W'(adfc_pkg::MAX_BLOCK_FRAMES) : s1_len;
  assign blk_prod = PW'(len_clamped) * PW'(crate);
  assign prod_cur = s1_start ? blk_prod : prod;
  assign acc_cur  = s1_start ? '0 : acc;
  assign pos_cur  = s1_start ? '0 : in_pos;
  assign acc1     = acc_cur + STEP1;
  assign acc2     = acc_cur + STEP2;
  assign sel_prod = (adfc_pkg::SEL_W'(pos_cur) + adfc_pkg::SEL_W'(1))
                  * adfc_pkg::SEL_W'(crate);
  assign emit     = (acc1 <= prod_cur) && (adfc_pkg::SEL_W'(acc_cur) < sel_prod);
  assign last     = acc2 > prod_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pos <= '0;
      prod   <= '0;
      acc    <= '0;
    end else if (s1_move) begin
      in_pos <= (&pos_cur) ? pos_cur : pos_cur + adfc_pkg::POS_W'(1);
      prod   <= prod_cur;
      acc    <= emit ? acc1 : acc_cur;
    end
  end

  // Output formatting
  assign ctrl.eight  = 32'(target_bits) < adfc_pkg::BITS_THRESHOLD;
  assign ctrl.stereo = keep_stereo;

  adfc_format u_format (
    .left_sample  (s1_left),
    .right_sample (s1_right),
    .ctrl         (ctrl),
    .first_value  (fmt_first),
    .second_value (fmt_second)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      out_first  <= fmt_first;
      out_second <= fmt_second;
      out_eight  <= ctrl.eight;
      out_stereo <= ctrl.stereo;
      out_last   <= last;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.first_value   = out_first;
  assign out_ch.second_value  = out_second;
  assign out_ch.is_eight_bit  = out_eight;
  assign out_ch.is_stereo     = out_stereo;
  assign out_ch.last_of_block = out_last;

  `ADFC_ASSERT_ALWAYS(a_acc_within_block, acc <= prod, "output count exceeds block limit")
  `ADFC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ch.ready, "input stalled with empty output")
  `ADFC_ASSERT_SAME(a_mono_second_zero, out_valid && !out_stereo, out_second == '0,
                    "mono item carries a second value")
  `ADFC_ASSERT_NEXT(a_pos_advance, s1_move && !s1_start, in_pos >= $past(in_pos),
                    "input position went backward within a block")

endmodule

// ----- design/adfc_format.sv -----
// Sample formatter: 16/8-bit width selection and stereo or mono mix.
module adfc_format (
  input  logic signed [adfc_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [adfc_pkg::SAMPLE_W-1:0] right_sample,
  input  adfc_pkg::fmt_ctrl_t                  ctrl,
  output logic signed [adfc_pkg::SAMPLE_W-1:0] first_value,
  output logic signed [adfc_pkg::SAMPLE_W-1:0] second_value
);

  logic signed [adfc_pkg::SAMPLE_W:0] sum;

  assign sum = {left_sample[adfc_pkg::SAMPLE_W-1], left_sample}
             + {right_sample[adfc_pkg::SAMPLE_W-1], right_sample};

  always_comb begin
    if (ctrl.stereo) begin
      if (ctrl.eight) begin
        first_value  = {{8{left_sample[15]}}, left_sample[15:8]};
        second_value = {{8{right_sample[15]}}, right_sample[15:8]};
      end else begin
        first_value  = left_sample;
        second_value = right_sample;
      end
    end else begin
      if (ctrl.eight) begin
        first_value = {{8{sum[16]}}, sum[16:9]};
      end else begin
        first_value = sum[16:1];
      end
      second_value = '0;
    end
  end

endmodule

// ----- sim/adfc_frame_check.sv -----
`timescale 1ns / 1ps
// Frame checker: predicts each converted output frame from accepted input frames and compares.
module adfc_frame_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [adfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adfc_pkg::CFG_DATA_W-1:0] cfg_data,
  adfc_in_if                              in_mon,
  adfc_out_if                             out_mon,
  output int                              pending,
  output int                              failures
);

  localparam logic [adfc_pkg::POS_W-1:0] POS_MAX = {adfc_pkg::POS_W{1'b1}};

  typedef struct packed {
    logic signed [adfc_pkg::SAMPLE_W-1:0] first_value;
    logic signed [adfc_pkg::SAMPLE_W-1:0] second_value;
    logic                                 is_eight_bit;
    logic                                 is_stereo;
    logic                                 last_of_block;
  } conv_frame_t;

  logic [adfc_pkg::RATE_W-1:0] rate_reg;
  logic [adfc_pkg::BITS_W-1:0] bits_reg;
  logic                        stereo_reg;
  logic [adfc_pkg::POS_W-1:0]  in_pos;
  logic [adfc_pkg::POS_W-1:0]  out_pos;
  logic [adfc_pkg::POS_W-1:0]  out_limit;
  conv_frame_t                 frame_q[$];
  int                          err_cnt;

  function automatic bit convert_frame(input logic signed [adfc_pkg::SAMPLE_W-1:0] left,
                                       input logic signed [adfc_pkg::SAMPLE_W-1:0] right,
                                       input logic start,
                                       input logic [adfc_pkg::LEN_W-1:0] frames,
                                       output conv_frame_t res);
    logic [adfc_pkg::CRATE_W-1:0] rate_c;
    logic [adfc_pkg::LEN_W-1:0]   len;
    logic signed [16:0]           mix;
    logic                         eight;
    logic                         keep;
    if (rate_reg > adfc_pkg::SOURCE_RATE) rate_c = adfc_pkg::CRATE_W'(adfc_pkg::SOURCE_RATE);
    else if (rate_reg == '0) rate_c = adfc_pkg::CRATE_W'(1);
    else rate_c = rate_reg[adfc_pkg::CRATE_W-1:0];
    eight = (bits_reg < adfc_pkg::BITS_THRESHOLD);
    if (start) begin
      len = (frames > adfc_pkg::MAX_BLOCK_FRAMES)
          ? adfc_pkg::LEN_W'(adfc_pkg::MAX_BLOCK_FRAMES) : frames;
      in_pos = '0;
      out_pos = '0;
      out_limit = adfc_pkg::POS_W'((64'(len) * 64'(rate_c)) / 64'(adfc_pkg::SOURCE_RATE));
    end
    keep = (out_pos < out_limit) &&
           (64'(out_pos) * 64'(adfc_pkg::SOURCE_RATE) < (64'(in_pos) + 64'd1) * 64'(rate_c));
    if (in_pos != POS_MAX) in_pos = in_pos + adfc_pkg::POS_W'(1);
    res = '0;
    if (keep) begin
      if (stereo_reg) begin
        res.first_value = eight ? (left >>> 8) : left;
        res.second_value = eight ? (right >>> 8) : right;
      end else begin
        mix = $signed({left[adfc_pkg::SAMPLE_W-1], left})
            + $signed({right[adfc_pkg::SAMPLE_W-1], right});
        res.first_value = eight ? adfc_pkg::SAMPLE_W'(mix >>> 9)
                                : adfc_pkg::SAMPLE_W'(mix >>> 1);
        res.second_value = '0;
      end
      res.is_eight_bit = eight;
      res.is_stereo = stereo_reg;
      res.last_of_block = (out_pos + adfc_pkg::POS_W'(1) == out_limit);
      out_pos = out_pos + adfc_pkg::POS_W'(1);
    end
    return keep;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    conv_frame_t want;
    conv_frame_t got;
    if (rst) begin
      rate_reg = adfc_pkg::RATE_RESET;
      bits_reg = adfc_pkg::BITS_RESET;
      stereo_reg = adfc_pkg::STEREO_RESET;
      in_pos = '0;
      out_pos = '0;
      out_limit = '0;
      frame_q.delete();
      err_cnt = 0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          adfc_pkg::CFG_TARGET_RATE: rate_reg = cfg_data[adfc_pkg::RATE_W-1:0];
          adfc_pkg::CFG_TARGET_BITS: bits_reg = cfg_data[adfc_pkg::BITS_W-1:0];
          adfc_pkg::CFG_KEEP_STEREO: stereo_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.first_value = out_mon.first_value;
        got.second_value = out_mon.second_value;
        got.is_eight_bit = out_mon.is_eight_bit;
        got.is_stereo = out_mon.is_stereo;
        got.last_of_block = out_mon.last_of_block;
        if (frame_q.size() == 0) begin
          $error("unexpected output item: first_value %0d, second_value %0d",
                 $signed(got.first_value), $signed(got.second_value));
          err_cnt++;
        end else begin
          want = frame_q.pop_front();
          check_field("first_value", $signed(want.first_value), $signed(got.first_value));
          check_field("second_value", $signed(want.second_value), $signed(got.second_value));
          check_field("is_eight_bit", want.is_eight_bit, got.is_eight_bit);
          check_field("is_stereo", want.is_stereo, got.is_stereo);
          check_field("last_of_block", want.last_of_block, got.last_of_block);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (convert_frame(in_mon.left_sample, in_mon.right_sample, in_mon.block_start,
                          in_mon.block_frames, want))
          frame_q.push_back(want);
      end
    end
    pending <= frame_q.size();
    failures <= err_cnt;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives frames and register writes into the converter and gives the verdict.
module tb;

  localparam logic [adfc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            cfg_en;
  logic [adfc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [adfc_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              pending;
  int                              failures;
  int                              send_idle_pct;
  int                              recv_stall_pct;
  bit                              pressure_go;

  adfc_in_if  in_ch ();
  adfc_out_if out_ch ();

  audio_decimating_format_converter_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  adfc_frame_check frame_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .pending   (pending),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [adfc_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic start, input logic [adfc_pkg::LEN_W-1:0] frames,
                            input logic signed [adfc_pkg::SAMPLE_W-1:0] left,
                            input logic signed [adfc_pkg::SAMPLE_W-1:0] right);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.block_start <= start;
    in_ch.block_frames <= frames;
    in_ch.left_sample <= left;
    in_ch.right_sample <= right;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [adfc_pkg::CFG_DATA_W-1:0] rate,
                            input logic [adfc_pkg::CFG_DATA_W-1:0] bits,
                            input logic [adfc_pkg::CFG_DATA_W-1:0] stereo,
                            input bit poke_unused);
    cfg_en <= 1'b1;
    cfg_index <= adfc_pkg::CFG_TARGET_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= adfc_pkg::CFG_TARGET_BITS;
    cfg_data <= bits;
    @(posedge clk);
    cfg_index <= adfc_pkg::CFG_KEEP_STEREO;
    cfg_data <= stereo;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED_IDX;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_en <= 1'b0;
  endtask

  task automatic run_blocks(input int n_items);
    int sent;
    int len;
    int count;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: len = 0;
        1: len = $urandom_range(8191, 4097);
        2: len = $urandom_range(4096, 25);
        default: len = $urandom_range(24, 1);
      endcase
      count = (len > 30) ? $urandom_range(30, 1) : len;
      if ($urandom_range(3) == 0) count += $urandom_range(3, 1);
      else if (count > 1 && $urandom_range(4) == 0) count = $urandom_range(count - 1, 1);
      if (count == 0) count = 1;
      for (int i = 0; i < count; i++) begin
        send_frame(i == 0, (i == 0) ? adfc_pkg::LEN_W'(len) : adfc_pkg::LEN_W'($urandom),
                   pick_sample(), pick_sample());
      end
      sent += count;
    end
  endtask

  initial begin : stimulus
    logic [adfc_pkg::CFG_DATA_W-1:0] rate;
    logic [adfc_pkg::BITS_W-1:0]     bits;
    rst <= 1'b1;
    cfg_en <= 1'b0;
    cfg_index <= adfc_pkg::CFG_TARGET_RATE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.block_start <= 1'b0;
    in_ch.block_frames <= '0;
    in_ch.left_sample <= '0;
    in_ch.right_sample <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_go = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 16-bit stereo at full rate after reset
    send_frame(1'b0, 13'd0, 16'sh1234, 16'sh4321);
    send_frame(1'b1, 13'd3, 16'sh7FFF, 16'sh8000);
    send_frame(1'b0, 13'h1FFF, 16'sh8000, 16'sh7FFF);
    send_frame(1'b0, 13'd0, 16'sh0000, 16'shFFFF);
    send_frame(1'b0, 13'd0, 16'shFFFF, 16'sh0001);
    send_frame(1'b1, 13'd0, 16'sh0064, 16'sh00C8);
    send_frame(1'b1, 13'h1FFF, 16'sh7FFF, 16'sh7FFF);
    drain();
    // 8-bit stereo, same block
    set_config(16'd16000, 16'd11, 16'd1, 1'b0);
    send_frame(1'b0, 13'd0, 16'sh8000, 16'shFFFF);
    send_frame(1'b0, 13'd0, 16'sh0100, 16'sh00FF);
    drain();
    // 8-bit mono
    set_config(16'd16000, 16'd11, 16'hFFFE, 1'b0);
    send_frame(1'b0, 13'd0, 16'sh7FFF, 16'sh7FFF);
    send_frame(1'b0, 13'd0, 16'sh8000, 16'sh8000);
    send_frame(1'b0, 13'd0, 16'shFFFF, 16'sh0000);
    drain();
    // 16-bit mono, with a write to an unused index
    set_config(16'd16000, 16'd12, 16'd0, 1'b1);
    send_frame(1'b0, 13'd0, 16'sh7FFF, 16'sh7FFF);
    send_frame(1'b0, 13'd0, 16'sh8000, 16'sh8000);
    send_frame(1'b0, 13'd0, 16'shFFFF, 16'sh0000);
    drain();
    // zero rate clamps to one: nothing comes out
    set_config(16'd0, 16'd255, 16'd1, 1'b0);
    send_frame(1'b1, 13'd4096, 16'sh1111, 16'sh2222);
    send_frame(1'b0, 13'd0, 16'sh3333, 16'sh4444);
    drain();
    set_config(16'hFFFF, 16'd255, 16'd1, 1'b0);
    send_frame(1'b1, 13'd5, 16'sh5555, 16'shAAAA);
    drain();
    // half rate, bits with upper byte set
    set_config(16'd8000, 16'hAB0C, 16'd1, 1'b0);
    for (int i = 0; i < 6; i++) send_frame(i == 0, 13'd5, pick_sample(), pick_sample());
    drain();

    // fill the block while the output holds off
    set_config(16'd16000, 16'd16, 16'd1, 1'b0);
    pressure_go = 1'b1;
    for (int i = 0; i < 40; i++) send_frame(i == 0, 13'd40, pick_sample(), pick_sample());
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case ($urandom_range(9))
        0: rate = 16'd0;
        1: rate = 16'd1;
        2: rate = 16'hFFFF;
        3: rate = 16'd16000;
        4: rate = 16'($urandom_range(65535, 16001));
        default: rate = 16'($urandom_range(16000, 1000));
      endcase
      case ($urandom_range(5))
        0: bits = 8'd0;
        1: bits = 8'd11;
        2: bits = 8'd12;
        3: bits = 8'd255;
        default: bits = 8'($urandom);
      endcase
      set_config(rate, {8'($urandom), bits}, 16'($urandom), $urandom_range(3) == 0);
      run_blocks(60);
      drain();
    end

    if (failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
